// ===== hw/rtl/prm_pkg.sv =====
// ----------------------------------------------------------------------------
// prm_pkg
// Shared types and constants of the reference patch mask block: divider
// request and response, operand widths and register indexes.
// ----------------------------------------------------------------------------
package prm_pkg;

   localparam int DIVIDEND_W = 12;
   localparam int DIVISOR_W  = 7;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_ROWS    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_COLS    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CROP_BORDERS = 3'd6;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
      logic [DIVISOR_W-1:0]  remainder;
   } div_rsp_type;

endpackage

// ===== hw/rtl/patch_reference_mask.sv =====
// ----------------------------------------------------------------------------
// patch_reference_mask
// Decides per voxel whether a reference patch starts there and keeps a
// running count of selected voxels.
// ----------------------------------------------------------------------------
// A new request is taken only once the last one is through: it is accepted in
// idle, the prep state finds the processing region and the edge flags, then seven
// divisions by the configured steps run one after another on a single 12-bit
// radix-2 divider, and the finish state forms the result. The input is not
// ready while a request is at work; a finished result waits in the output
// register while the next request is taken, and the result step holds for as
// long as that register is still full.
module patch_reference_mask #(
   parameter int PATCH_SIDE   = 5,
   parameter int PATCH_DEPTH  = 2,
   parameter int SEARCH_SIDE  = 27,
   parameter int SEARCH_DEPTH = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [5:0]                    req_frame_index,
   input  logic [10:0]                   req_row_index,
   input  logic [10:0]                   req_col_index,
   input  logic                          req_restart_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_selected,
   output logic [28:0]                   rsp_group_count,
   input  logic                          csr_write_enable,
   input  logic [prm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [prm_pkg::CSR_DATA_W-1:0] csr_write_data
);

   localparam int BS = PATCH_SIDE - 1 + SEARCH_SIDE / 2;
   localparam int BT = PATCH_DEPTH - 1 + SEARCH_DEPTH / 2;
   localparam logic signed [13:0] BS_S = 14'(BS);
   localparam logic signed [13:0] BT_S = 14'(BT);
   localparam logic signed [13:0] PS_S = 14'(PATCH_SIDE - 1);
   localparam logic signed [13:0] PD_S = 14'(PATCH_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PREP,
      S_ISSUE,
      S_WAIT,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_REM_T,
      OP_QUO_T,
      OP_REM_DH,
      OP_REM_PH,
      OP_QUO_H,
      OP_REM_DW,
      OP_REM_PW
   } op_type;

   // configuration
   logic [6:0]  frame_count_ff;
   logic [11:0] frame_height_ff, frame_width_ff;
   logic [6:0]  step_time_ff, step_rows_ff, step_cols_ff;
   logic [5:0]  crop_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff  <= 7'd16;
         frame_height_ff <= 12'd480;
         frame_width_ff  <= 12'd640;
         step_time_ff    <= 7'd1;
         step_rows_ff    <= 7'd4;
         step_cols_ff    <= 7'd4;
         crop_ff         <= 6'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            prm_pkg::CSR_FRAME_COUNT:  frame_count_ff  <= csr_write_data[6:0];
            prm_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_write_data;
            prm_pkg::CSR_FRAME_WIDTH:  frame_width_ff  <= csr_write_data;
            prm_pkg::CSR_STEP_TIME:    step_time_ff    <= csr_write_data[6:0];
            prm_pkg::CSR_STEP_ROWS:    step_rows_ff    <= csr_write_data[6:0];
            prm_pkg::CSR_STEP_COLS:    step_cols_ff    <= csr_write_data[6:0];
            prm_pkg::CSR_CROP_BORDERS: crop_ff         <= csr_write_data[5:0];
            default: ;
         endcase
      end
   end

   logic [6:0] st, sh, sw;
   assign st = (step_time_ff == '0) ? 7'd1 : step_time_ff;
   assign sh = (step_rows_ff == '0) ? 7'd1 : step_rows_ff;
   assign sw = (step_cols_ff == '0) ? 7'd1 : step_cols_ff;

   // request holding registers and sequencer state
   state_type   state_ff, state_in;
   op_type      op_ff, op_in;
   logic [5:0]  t_ff, t_in;
   logic [10:0] h_ff, h_in;
   logic [10:0] w_ff, w_in;
   logic        restart_ff, restart_in;
   logic        inside_ff, inside_in;
   logic        last_t_ff, last_t_in;
   logic        last_h_ff, last_h_in;
   logic        last_w_ff, last_w_in;
   logic        first_h_ff, first_h_in;
   logic        first_w_ff, first_w_in;
   logic [5:0]  dt_ff, dt_in;
   logic [10:0] dh_ff, dh_in;
   logic [10:0] dw_ff, dw_in;
   logic [6:0]  rem_t_ff, rem_t_in;
   logic [5:0]  q_t_ff, q_t_in;
   logic [6:0]  rem_dh_ff, rem_dh_in;
   logic [6:0]  rem_ph_ff, rem_ph_in;
   logic [10:0] q_h_ff, q_h_in;
   logic [6:0]  rem_dw_ff, rem_dw_in;
   logic [6:0]  rem_pw_ff, rem_pw_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_sel_ff, rsp_sel_in;
   logic [28:0] total_ff, total_in;

   // region
   logic signed [13:0] ori_t, ori_h, ori_w, end_t, end_h, end_w, ct, ch, cw;
   assign ori_w = crop_ff[0] ? BS_S : 14'sd0;
   assign ori_h = crop_ff[1] ? BS_S : 14'sd0;
   assign ori_t = crop_ff[2] ? BT_S : 14'sd0;
   assign end_w = $signed({2'b00, frame_width_ff}) - (crop_ff[3] ? BS_S : PS_S);
   assign end_h = $signed({2'b00, frame_height_ff}) - (crop_ff[4] ? BS_S : PS_S);
   assign end_t = $signed({7'd0, frame_count_ff}) - (crop_ff[5] ? BT_S : PD_S);
   assign ct = $signed({8'd0, t_ff});
   assign ch = $signed({3'd0, h_ff});
   assign cw = $signed({3'd0, w_ff});

   // phases
   logic [5:0]  phase_h;
   logic [11:0] phase_w;
   assign phase_h = last_t_ff ? 6'd0 : q_t_ff;
   assign phase_w = last_h_ff ? 12'd0 : ({6'd0, phase_h} + {1'b0, q_h_ff});

   // shared divider
   prm_pkg::div_req_type div_req;
   prm_pkg::div_rsp_type div_rsp;

   prm_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      div_req.start = (state_ff == S_ISSUE);
      case (op_ff)
         OP_REM_T:  begin div_req.dividend = {6'd0, dt_ff};   div_req.divisor = st; end
         OP_QUO_T:  begin div_req.dividend = {6'd0, t_ff};    div_req.divisor = st; end
         OP_REM_DH: begin div_req.dividend = {1'b0, dh_ff};   div_req.divisor = sh; end
         OP_REM_PH: begin div_req.dividend = {6'd0, phase_h}; div_req.divisor = sh; end
         OP_QUO_H:  begin div_req.dividend = {1'b0, h_ff};    div_req.divisor = sh; end
         OP_REM_DW: begin div_req.dividend = {1'b0, dw_ff};   div_req.divisor = sw; end
         OP_REM_PW: begin div_req.dividend = phase_w;         div_req.divisor = sw; end
         default:   begin div_req.dividend = '0;              div_req.divisor = sw; end
      endcase
   end

   logic        sel;
   logic [28:0] base;
   assign sel = inside_ff
              && (rem_t_ff == '0 || last_t_ff)
              && (rem_dh_ff == rem_ph_ff || last_h_ff || first_h_ff)
              && (rem_dw_ff == rem_pw_ff || last_w_ff || first_w_ff);
   assign base = restart_ff ? 29'd0 : total_ff;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      t_in         = t_ff;
      h_in         = h_ff;
      w_in         = w_ff;
      restart_in   = restart_ff;
      inside_in    = inside_ff;
      last_t_in    = last_t_ff;
      last_h_in    = last_h_ff;
      last_w_in    = last_w_ff;
      first_h_in   = first_h_ff;
      first_w_in   = first_w_ff;
      dt_in        = dt_ff;
      dh_in        = dh_ff;
      dw_in        = dw_ff;
      rem_t_in     = rem_t_ff;
      q_t_in       = q_t_ff;
      rem_dh_in    = rem_dh_ff;
      rem_ph_in    = rem_ph_ff;
      q_h_in       = q_h_ff;
      rem_dw_in    = rem_dw_ff;
      rem_pw_in    = rem_pw_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_sel_in   = rsp_sel_ff;
      total_in     = total_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               t_in       = req_frame_index;
               h_in       = req_row_index;
               w_in       = req_col_index;
               restart_in = req_restart_count;
               state_in   = S_PREP;
            end
         end
         S_PREP: begin
            inside_in  = ct >= ori_t && ct < end_t && ch >= ori_h && ch < end_h
                       && cw >= ori_w && cw < end_w;
            last_t_in  = !crop_ff[5] && ct == end_t - 14'sd1;
            last_h_in  = !crop_ff[4] && ch == end_h - 14'sd1;
            last_w_in  = !crop_ff[3] && cw == end_w - 14'sd1;
            first_h_in = !crop_ff[1] && ch == ori_h;
            first_w_in = !crop_ff[0] && cw == ori_w;
            dt_in      = t_ff - ori_t[5:0];
            dh_in      = h_ff - ori_h[10:0];
            dw_in      = w_ff - ori_w[10:0];
            op_in      = OP_REM_T;
            state_in   = S_ISSUE;
         end
         S_ISSUE: begin
            state_in = S_WAIT;
         end
         S_WAIT: begin
            if (div_rsp.done) begin
               case (op_ff)
                  OP_REM_T:  rem_t_in  = div_rsp.remainder;
                  OP_QUO_T:  q_t_in    = div_rsp.quotient[5:0];
                  OP_REM_DH: rem_dh_in = div_rsp.remainder;
                  OP_REM_PH: rem_ph_in = div_rsp.remainder;
                  OP_QUO_H:  q_h_in    = div_rsp.quotient[10:0];
                  OP_REM_DW: rem_dw_in = div_rsp.remainder;
                  default:   rem_pw_in = div_rsp.remainder;
               endcase
               if (op_ff == OP_REM_PW) begin
                  state_in = S_FINISH;
               end else begin
                  op_in    = op_type'(op_ff + 3'd1);
                  state_in = S_ISSUE;
               end
            end
         end
         S_FINISH: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               total_in     = base + {28'd0, sel};
               rsp_sel_in   = sel;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
      op_ff      <= op_in;
      t_ff       <= t_in;
      h_ff       <= h_in;
      w_ff       <= w_in;
      restart_ff <= restart_in;
      inside_ff  <= inside_in;
      last_t_ff  <= last_t_in;
      last_h_ff  <= last_h_in;
      last_w_ff  <= last_w_in;
      first_h_ff <= first_h_in;
      first_w_ff <= first_w_in;
      dt_ff      <= dt_in;
      dh_ff      <= dh_in;
      dw_ff      <= dw_in;
      rem_t_ff   <= rem_t_in;
      q_t_ff     <= q_t_in;
      rem_dh_ff  <= rem_dh_in;
      rem_ph_ff  <= rem_ph_in;
      q_h_ff     <= q_h_in;
      rem_dw_ff  <= rem_dw_in;
      rem_pw_ff  <= rem_pw_in;
      rsp_sel_ff <= rsp_sel_in;
   end

   assign req_ready       = (state_ff == S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_selected    = rsp_sel_ff;
   assign rsp_group_count = total_ff;

endmodule

// ===== hw/rtl/prm_divider.sv =====
// ----------------------------------------------------------------------------
// prm_divider
// Radix-2 restoring divider, one quotient bit per cycle. The divisor must be
// nonzero. Done pulses for one cycle once quotient and remainder are final.
// ----------------------------------------------------------------------------
module prm_divider (
   input  logic                clock,
   input  logic                reset,
   input  prm_pkg::div_req_type div_req,
   output prm_pkg::div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(prm_pkg::DIVIDEND_W);

   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [CNT_W-1:0]                cnt_ff, cnt_in;
   logic [prm_pkg::DIVIDEND_W-1:0]  quo_ff, quo_in;
   logic [prm_pkg::DIVISOR_W-1:0]   rem_ff, rem_in;
   logic [prm_pkg::DIVISOR_W-1:0]   div_ff, div_in;
   logic [prm_pkg::DIVISOR_W:0]     partial;
   logic                            ge;

   assign partial = {rem_ff, quo_ff[prm_pkg::DIVIDEND_W-1]};
   assign ge      = partial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(prm_pkg::DIVIDEND_W - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[prm_pkg::DIVIDEND_W-2:0], ge};
         rem_in = ge ? prm_pkg::DIVISOR_W'(partial - {1'b0, div_ff})
                     : partial[prm_pkg::DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
